>>> rtl/core/iodca_pkg.sv
package iodca_pkg;

  localparam int unsigned LineBytes  = 8;
  localparam int unsigned MaxOpBytes = 8;
  localparam int unsigned OffW       = $clog2(LineBytes);

  localparam logic [2:0] FuncRead  = 3'd0;
  localparam logic [2:0] FuncWrite = 3'd1;
  localparam logic [2:0] FuncFlush = 3'd2;
  localparam logic [2:0] FuncLine  = 3'd3;
  localparam logic [2:0] FuncAck   = 3'd4;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindMRead  = 3'd1;
  localparam logic [2:0] KindMWrite = 3'd2;
  localparam logic [2:0] KindResp   = 3'd3;
  localparam logic [2:0] KindBusy   = 3'd4;
  localparam logic [2:0] KindSize   = 3'd5;
  localparam logic [2:0] KindPerm   = 3'd6;
  localparam logic [2:0] KindStray  = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] address;
    logic [3:0]  size;
    logic [7:0]  client;
    logic [63:0] payload;
    logic        access_allowed;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] out_address;
    logic [7:0]  out_client;
    logic [3:0]  out_size;
    logic [63:0] out_data;
    logic [7:0]  byte_mask;
  } rsp_t;

endpackage

>>> rtl/core/io_direct_cache_access_bridge.sv
// Datapath: each input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while results are taken; a result held at the output
// does not stop intake while the input register is free.
// Reset: asynchronous, active low; clears the pending write count, the outstanding
// read/flush tracking and both valid flags.
module io_direct_cache_access_bridge (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  iodca_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iodca_pkg::rsp_t out_rsp_o
);
  import iodca_pkg::*;

  logic        in_valid_q;
  req_t        in_q;
  logic        out_valid_q;
  rsp_t        out_q, rsp_d;
  logic        out_free, advance;

  logic [15:0] pend_q, pend_d;
  logic        flush_q, flush_d;
  logic        ost_valid_q, ost_valid_d;
  logic [7:0]  ost_dev_q, ost_dev_d;
  logic [63:0] ost_addr_q, ost_addr_d;
  logic [3:0]  ost_size_q, ost_size_d;

  function automatic logic [7:0] size_be(input logic [3:0] n);
    logic [7:0] en;
    for (int i = 0; i < 8; i++) begin
      en[i] = (4'(i) < n);
    end
    return en;
  endfunction

  function automatic logic [63:0] be_bits(input logic [7:0] en);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{en[i]}};
    end
    return m;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  logic [OffW-1:0] offset, ooff;
  logic [63:0]     line_addr, oline_addr;
  logic [4:0]      end_byte;
  logic            size_bad;
  logic [7:0]      be;

  always_comb begin
    offset     = in_q.address[OffW-1:0];
    line_addr  = {in_q.address[63:OffW], {OffW{1'b0}}};
    ooff       = ost_addr_q[OffW-1:0];
    oline_addr = {ost_addr_q[63:OffW], {OffW{1'b0}}};
    end_byte   = 5'(offset) + 5'(in_q.size);
    size_bad   = (in_q.size == 4'd0) || (in_q.size > 4'(MaxOpBytes)) ||
                 (end_byte > 5'(LineBytes));
    be         = size_be(in_q.size);

    pend_d      = pend_q;
    flush_d     = flush_q;
    ost_valid_d = ost_valid_q;
    ost_dev_d   = ost_dev_q;
    ost_addr_d  = ost_addr_q;
    ost_size_d  = ost_size_q;
    rsp_d       = '0;
    rsp_d.kind  = KindNone;

    unique case (in_q.func)
      FuncRead, FuncWrite: begin
        if (size_bad) begin
          rsp_d.kind        = KindSize;
          rsp_d.out_address = in_q.address;
          rsp_d.out_client  = in_q.client;
        end else if (!in_q.access_allowed) begin
          rsp_d.kind        = KindPerm;
          rsp_d.out_address = in_q.address;
          rsp_d.out_client  = in_q.client;
        end else if (in_q.func == FuncRead) begin
          if (ost_valid_q) begin
            rsp_d.kind        = KindBusy;
            rsp_d.out_address = in_q.address;
            rsp_d.out_client  = in_q.client;
          end else begin
            ost_valid_d       = 1'b1;
            ost_dev_d         = in_q.client;
            ost_addr_d        = in_q.address;
            ost_size_d        = in_q.size;
            rsp_d.kind        = KindMRead;
            rsp_d.out_address = line_addr;
            rsp_d.out_client  = in_q.client;
            rsp_d.out_size    = in_q.size;
          end
        end else begin
          if (pend_q != 16'hFFFF) begin
            pend_d = pend_q + 16'd1;
          end
          rsp_d.kind        = KindMWrite;
          rsp_d.out_address = line_addr;
          rsp_d.out_client  = in_q.client;
          rsp_d.out_size    = in_q.size;
          rsp_d.out_data    = (in_q.payload & be_bits(be)) << {offset, 3'b000};
          rsp_d.byte_mask   = be << offset;
        end
      end
      FuncFlush: begin
        if (ost_valid_q) begin
          rsp_d.kind        = KindBusy;
          rsp_d.out_address = in_q.address;
          rsp_d.out_client  = in_q.client;
        end else if (pend_q == 16'd0) begin
          rsp_d.kind       = KindResp;
          rsp_d.out_client = in_q.client;
        end else begin
          flush_d     = 1'b1;
          ost_valid_d = 1'b1;
          ost_dev_d   = in_q.client;
          ost_addr_d  = '0;
          ost_size_d  = '0;
        end
      end
      FuncLine: begin
        if (ost_valid_q && !flush_q && (oline_addr == line_addr)) begin
          ost_valid_d       = 1'b0;
          rsp_d.kind        = KindResp;
          rsp_d.out_address = ost_addr_q;
          rsp_d.out_client  = ost_dev_q;
          rsp_d.out_size    = ost_size_q;
          rsp_d.out_data    = (in_q.payload >> {ooff, 3'b000}) &
                              be_bits(size_be(ost_size_q));
        end
      end
      FuncAck: begin
        if (pend_q == 16'd0) begin
          rsp_d.kind = KindStray;
        end else begin
          pend_d = pend_q - 16'd1;
          if ((pend_q == 16'd1) && flush_q) begin
            flush_d          = 1'b0;
            ost_valid_d      = 1'b0;
            rsp_d.kind       = KindResp;
            rsp_d.out_client = ost_dev_q;
          end
        end
      end
      default: begin
        rsp_d.kind = KindNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      flush_q     <= 1'b0;
      ost_valid_q <= 1'b0;
      ost_dev_q   <= '0;
      ost_addr_q  <= '0;
      ost_size_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        pend_q      <= pend_d;
        flush_q     <= flush_d;
        ost_valid_q <= ost_valid_d;
        ost_dev_q   <= ost_dev_d;
        ost_addr_q  <= ost_addr_d;
        ost_size_q  <= ost_size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_flush_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> ost_valid_q)
    else $error("flush waiting without outstanding entry");

  a_flush_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (pend_q != 16'd0))
    else $error("flush waiting with no pending writes");

  a_write_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.kind == KindMWrite)) |-> (out_rsp_o.byte_mask != 8'd0))
    else $error("memory write beat with empty byte mask");

  a_read_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (rsp_d.kind == KindMRead)) |=> (ost_valid_q && !flush_q))
    else $error("memory read issued without outstanding entry");
`endif

endmodule

>>> tb/bridge_result_check.sv
`timescale 1ns / 100ps
module bridge_result_check (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  iodca_pkg::req_t in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  iodca_pkg::rsp_t out_rsp_i,
  output int unsigned     err_cnt_o,
  output int unsigned     due_cnt_o
);
  import iodca_pkg::*;

  logic [15:0] wr_open     = '0;
  logic        flush_wait  = 1'b0;
  logic        held_valid  = 1'b0;
  logic [7:0]  held_client = '0;
  logic [63:0] held_addr   = '0;
  logic [3:0]  held_size   = '0;
  int unsigned errs        = 0;
  rsp_t        rsp_due_q[$];

  function automatic logic [63:0] low_bytes(input int unsigned n);
    if (n >= 8) return {64{1'b1}};
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Bridge behaviour for one event; updates the tracked state.
  function automatic rsp_t next_rsp(input req_t r);
    rsp_t        o;
    int unsigned off;
    int unsigned held_off;
    logic [63:0] line;
    logic [15:0] mask;
    o    = '0;
    off  = r.address % LineBytes;
    line = r.address - off;
    case (r.func)
      FuncRead, FuncWrite: begin
        if (r.size == 0 || r.size > MaxOpBytes || off + r.size > LineBytes) begin
          o.kind        = KindSize;
          o.out_address = r.address;
          o.out_client  = r.client;
        end else if (!r.access_allowed) begin
          o.kind        = KindPerm;
          o.out_address = r.address;
          o.out_client  = r.client;
        end else if (r.func == FuncRead) begin
          o.out_client = r.client;
          if (held_valid) begin
            o.kind        = KindBusy;
            o.out_address = r.address;
          end else begin
            held_valid    = 1'b1;
            held_client   = r.client;
            held_addr     = r.address;
            held_size     = r.size;
            o.kind        = KindMRead;
            o.out_address = line;
            o.out_size    = r.size;
          end
        end else begin
          mask          = ((16'd1 << r.size) - 16'd1) << off;
          o.kind        = KindMWrite;
          o.out_address = line;
          o.out_client  = r.client;
          o.out_size    = r.size;
          o.out_data    = (r.payload & low_bytes(r.size)) << (8 * off);
          o.byte_mask   = mask[7:0];
          if (wr_open != 16'hFFFF) wr_open = wr_open + 16'd1;
        end
      end
      FuncFlush: begin
        if (held_valid) begin
          o.kind        = KindBusy;
          o.out_address = r.address;
          o.out_client  = r.client;
        end else if (wr_open == 0) begin
          o.kind       = KindResp;
          o.out_client = r.client;
        end else begin
          flush_wait  = 1'b1;
          held_valid  = 1'b1;
          held_client = r.client;
          held_addr   = '0;
          held_size   = '0;
        end
      end
      FuncLine: begin
        if (held_valid && !flush_wait) begin
          held_off = held_addr % LineBytes;
          if (held_addr - held_off == line) begin
            held_valid    = 1'b0;
            o.kind        = KindResp;
            o.out_address = held_addr;
            o.out_client  = held_client;
            o.out_size    = held_size;
            o.out_data    = (r.payload >> (8 * held_off)) & low_bytes(held_size);
          end
        end
      end
      FuncAck: begin
        if (wr_open == 0) begin
          o.kind = KindStray;
        end else begin
          wr_open = wr_open - 16'd1;
          if (wr_open == 0 && flush_wait) begin
            flush_wait   = 1'b0;
            held_valid   = 1'b0;
            o.kind       = KindResp;
            o.out_client = held_client;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      wr_open    = '0;
      flush_wait = 1'b0;
      held_valid = 1'b0;
      rsp_due_q.delete();
      err_cnt_o <= errs;
      due_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) rsp_due_q.push_back(next_rsp(in_req_i));
      if (out_valid_i && out_ready_i) begin
        got = out_rsp_i;
        if (rsp_due_q.size() == 0) begin
          if (errs < 10) $display("%0t: result beat with none due, kind %0d", $time, got.kind);
          errs++;
        end else begin
          want = rsp_due_q.pop_front();
          if (got.kind !== want.kind || got.out_address !== want.out_address ||
              got.out_client !== want.out_client || got.out_size !== want.out_size ||
              got.out_data !== want.out_data || got.byte_mask !== want.byte_mask) begin
            if (errs < 10) begin
              $display("%0t: result mismatch (expected / actual)", $time);
              $display("  kind %0d / %0d  addr %h / %h  client %h / %h", want.kind,
                       got.kind, want.out_address, got.out_address, want.out_client,
                       got.out_client);
              $display("  size %0d / %0d  data %h / %h  mask %h / %h", want.out_size,
                       got.out_size, want.out_data, got.out_data, want.byte_mask,
                       got.byte_mask);
            end
            errs++;
          end
        end
      end
      err_cnt_o <= errs;
      due_cnt_o <= rsp_due_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import iodca_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned RandomItems = 1400;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  req_t        in_req    = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  rsp_t        out_rsp;
  int unsigned err_cnt;
  int unsigned due_cnt;

  logic        quiet       = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] writes_open = '0;
  logic [63:0] last_read   = '0;
  int unsigned sent        = 0;

  io_direct_cache_access_bridge dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  bridge_result_check result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_i   (out_rsp),
    .err_cnt_o   (err_cnt),
    .due_cnt_o   (due_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(input logic [2:0] func, input logic [63:0] address,
                                    input logic [3:0] size, input logic [7:0] client,
                                    input logic [63:0] payload, input logic allowed);
    req_t r;
    r.func           = func;
    r.address        = address;
    r.size           = size;
    r.client         = client;
    r.payload        = payload;
    r.access_allowed = allowed;
    return r;
  endfunction

  // Mostly in-line, permitted requests; now and then a faulty size or permission.
  function automatic req_t aligned_req(input logic [2:0] func);
    int unsigned off;
    int unsigned sz;
    logic [63:0] a;
    off = $urandom_range(0, LineBytes - 1);
    sz  = $urandom_range(1, LineBytes - off);
    a   = rand64();
    a   = a - a % LineBytes + off;
    if ($urandom_range(0, 6) == 0)
      return make_req(func, a, 4'($urandom), 8'($urandom), rand64(), 1'($urandom));
    return make_req(func, a, 4'(sz), 8'($urandom), rand64(), 1'b1);
  endfunction

  function automatic req_t noise_req();
    return make_req(3'($urandom_range(1, 7)), rand64(), 4'($urandom), 8'($urandom),
                    rand64(), 1'($urandom));
  endfunction

  task automatic send(input req_t r);
    int unsigned gap;
    logic        good;
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    good = r.size != 0 && r.size <= MaxOpBytes && r.access_allowed &&
           r.address % LineBytes + r.size <= LineBytes;
    if (r.func == FuncWrite && good && writes_open != 16'hFFFF) writes_open++;
    if (r.func == FuncAck && writes_open != 0) writes_open--;
    if (r.func <= FuncAck) sent++;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
  endtask

  // Ack every open write (ends any flush) and return the last read's line.
  task automatic retire();
    int unsigned k;
    k = writes_open;
    repeat (k) send(make_req(FuncAck, rand64(), 4'($urandom), 8'($urandom), rand64(),
                             1'($urandom)));
    send(make_req(FuncLine, last_read, 4'($urandom), 8'($urandom), rand64(), 1'b1));
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t        r;
    int unsigned pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send(make_req(FuncAck, '0, '0, '0, '0, 1'b0));
    send(make_req(FuncFlush, '1, 4'hF, 8'hFF, '1, 1'b0));
    send(make_req(FuncRead, 64'h10, 4'd0, 8'h01, '0, 1'b1));
    send(make_req(FuncRead, 64'h10, 4'hF, 8'h02, '0, 1'b1));
    send(make_req(FuncWrite, 64'h27, 4'd2, 8'h03, '1, 1'b1));
    send(make_req(FuncWrite, 64'h20, 4'd4, 8'h04, '1, 1'b0));
    send(make_req(FuncWrite, 64'hFFFF_FFFF_FFFF_FFF8, 4'd8, 8'hFF, '1, 1'b1));
    send(make_req(FuncRead, '1, 4'd1, 8'hA5, '0, 1'b1));
    send(make_req(FuncRead, 64'h40, 4'd2, 8'h11, '0, 1'b1));
    send(make_req(FuncFlush, 64'h48, 4'd0, 8'h12, '0, 1'b1));
    send(make_req(FuncLine, '0, '0, '0, '1, 1'b1));
    send(make_req(FuncLine, 64'hFFFF_FFFF_FFFF_FFFB, '0, '0, 64'h8877_6655_4433_2211, 1'b1));
    send(make_req(FuncLine, '1, '0, '0, '1, 1'b1));
    send(make_req(FuncWrite, 64'h13, 4'd4, 8'h5A, 64'hDEAD_BEEF_CAFE_F00D, 1'b1));
    send(make_req(FuncFlush, '0, '0, 8'h3C, '0, 1'b0));
    send(make_req(FuncLine, '1, '0, '0, '1, 1'b1));
    send(make_req(FuncRead, 64'h8, 4'd8, 8'h21, '0, 1'b1));
    send(make_req(FuncWrite, 64'h30, 4'd1, 8'h22, 64'h1234, 1'b1));
    repeat (3) send(make_req(FuncAck, '0, '0, '0, '0, 1'b1));
    for (int f = 5; f < 8; f++) send(make_req(3'(f), '1, 4'hF, 8'hFF, '1, 1'b1));
    send(make_req(FuncRead, '0, 4'd8, 8'h00, '0, 1'b1));
    send(make_req(FuncLine, 64'h5, '0, '0, 64'h0102_0304_0506_0708, 1'b1));
    drain_wait();

    // random
    while (sent < RandomItems) begin
      if ($urandom_range(0, 29) == 0) quiet <= ~quiet;
      if ($urandom_range(0, 149) == 0) drain_wait();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        retire();
        r = aligned_req(FuncRead);
        send(r);
        last_read = r.address;
        if (pick < 10) send(aligned_req(pick < 5 ? FuncRead : FuncFlush));
        if ($urandom_range(0, 3) == 0)
          send(make_req(FuncLine, r.address ^ (64'd1 << $urandom_range(3, 63)),
                        4'($urandom), 8'($urandom), rand64(), 1'($urandom)));
        send(make_req(FuncLine, r.address ^ 64'($urandom_range(0, LineBytes - 1)),
                      4'($urandom), 8'($urandom), rand64(), 1'($urandom)));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6)) send(aligned_req(FuncWrite));
        if (pick < 50) begin
          send(aligned_req(FuncFlush));
          if (pick < 45) send(make_req(FuncLine, last_read, '0, '0, rand64(), 1'b1));
        end
        retire();
      end else if (pick < 80) begin
        retire();
        send(aligned_req(FuncFlush));
      end else begin
        send(noise_req());
      end
    end

    drain_wait();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && due_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
